// File: src/jter_pkg.sv
// ----------------------------------------------------------------------------
// JSON token reader package
// Shared constants, token and event codes, and the structs passed between
// the decode core and the event queue.
// ----------------------------------------------------------------------------
`default_nettype none

package jter_pkg;

  // Maximum nesting depth of open objects and arrays
  localparam int unsigned STACK_DEPTH = 32;
  // Significant bits of a string handle
  localparam int unsigned HANDLE_BITS = 16;

  localparam int unsigned LVL_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam logic [15:0] HMASK =
    (HANDLE_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << HANDLE_BITS) - 32'd1);

  // Event queue, depth must be a power of two
  localparam int unsigned EVQ_DEPTH = 4;
  localparam int unsigned EVQ_PTR_W = $clog2(EVQ_DEPTH);
  localparam int unsigned EVQ_CNT_W = $clog2(EVQ_DEPTH + 1);

  typedef enum logic [3:0] {
    TK_END       = 4'd0,
    TK_ERROR     = 4'd1,
    TK_OBJ_OPEN  = 4'd2,
    TK_OBJ_CLOSE = 4'd3,
    TK_ARR_OPEN  = 4'd4,
    TK_ARR_CLOSE = 4'd5,
    TK_COLON     = 4'd6,
    TK_COMMA     = 4'd7,
    TK_STRING    = 4'd8,
    TK_UNSIGNED  = 4'd9,
    TK_INTEGER   = 4'd10,
    TK_FLOAT     = 4'd11,
    TK_BOOL      = 4'd12,
    TK_NULL      = 4'd13
  } tok_e;

  typedef enum logic [3:0] {
    EV_END       = 4'd0,
    EV_ERROR     = 4'd1,
    EV_OBJ_OPEN  = 4'd2,
    EV_OBJ_CLOSE = 4'd3,
    EV_ARR_OPEN  = 4'd4,
    EV_ARR_CLOSE = 4'd5,
    EV_NAME      = 4'd6,
    EV_STRING    = 4'd7,
    EV_UNSIGNED  = 4'd8,
    EV_INTEGER   = 4'd9,
    EV_FLOAT     = 4'd10,
    EV_BOOL      = 4'd11,
    EV_NULL      = 4'd12
  } ev_e;

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] payload;
    logic [15:0] tref;
    logic [15:0] tlen;
  } tok_t;

  typedef struct packed {
    ev_e         code;
    logic [63:0] bits;
    logic [15:0] vref;
    logic [15:0] vlen;
    logic        has_key;
    logic [15:0] kref;
    logic [15:0] klen;
    logic        last;
  } evt_t;

  // Events produced by one token, cnt is 0, 1 or 2
  typedef struct packed {
    logic [1:0] cnt;
    evt_t       ev0;
    evt_t       ev1;
  } evq_wr_t;

endpackage

`default_nettype wire

// File: src/json_token_to_event_reader.sv
// ----------------------------------------------------------------------------
// JSON token to event reader
// Turns a stream of JSON tokens into open/close, name, value and error events.
// ----------------------------------------------------------------------------
// Takes one token per cycle while the event queue has room; produces zero,
// one or two events per token. A token is captured in an input register,
// decoded in one pass against the layer stack, pending key and colon flags,
// and its events are written into a four-entry event queue that drives the
// output ports. Sustained rate is one token per clock as long as the consumer
// takes one event per clock; a token that produces two events (a name event
// ahead of an object or array opened after a colon) takes an extra slot at
// the output, which the event queue absorbs and which stalls input only once
// the queue has fewer than two free slots. Strings and keys are passed as
// handle and length only; a string inside an object before its colon becomes
// the pending key and produces no event. Stack overflow yields an error
// event; a close on an empty stack is emitted but does not pop.
`default_nettype none

module json_token_to_event_reader (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // token request
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [3:0]  kind_i,
  input  wire logic [63:0] payload_i,
  input  wire logic [15:0] text_ref_i,
  input  wire logic [15:0] text_len_i,
  // event request
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       event_res_o,
  output logic [63:0]      value_bits_o,
  output logic [15:0]      value_ref_o,
  output logic [15:0]      value_len_o,
  output logic             has_key_o,
  output logic [15:0]      key_ref_o,
  output logic [15:0]      key_len_o,
  output logic             last_o
);

  jter_pkg::tok_t    tok_q;
  logic              tok_v_q;
  logic              fire;     // registered token decoded this cycle
  logic              room2;    // queue can take both events of any token
  jter_pkg::evq_wr_t wr;
  jter_pkg::evt_t    head;

  assign fire       = tok_v_q && room2;
  // input register frees when its token is decoded
  assign in_ready_o = !tok_v_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_v_q <= 1'b0;
    end else if (in_ready_o) begin
      tok_v_q <= in_valid_i;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      tok_q.kind    <= kind_i;
      tok_q.payload <= payload_i;
      tok_q.tref    <= text_ref_i;
      tok_q.tlen    <= text_len_i;
    end
  end

  jter_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .tok_i  (tok_q),
    .wr_o   (wr)
  );

  jter_evq u_evq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .pop_i   (out_ready_i),
    .room2_o (room2),
    .valid_o (out_valid_o),
    .head_o  (head)
  );

  assign event_res_o  = head.code;
  assign value_bits_o = head.bits;
  assign value_ref_o  = head.vref;
  assign value_len_o  = head.vlen;
  assign has_key_o    = head.has_key;
  assign key_ref_o    = head.kref;
  assign key_len_o    = head.klen;
  assign last_o       = head.last;

endmodule

`default_nettype wire

// File: src/jter_core.sv
// ----------------------------------------------------------------------------
// JSON token reader decode core
// Holds the layer stack, pending key and colon flags; turns one registered
// token into up to two events in a single pass.
// ----------------------------------------------------------------------------
`default_nettype none

module jter_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  wire jter_pkg::tok_t   tok_i,
  output jter_pkg::evq_wr_t     wr_o
);

  logic [jter_pkg::STACK_DEPTH-1:0] stack_q;
  logic [jter_pkg::LVL_W-1:0]       lvl_q, lvl_d, lvl_m1;
  logic [15:0]                      key_ref_q, key_ref_d, key_len_q, key_len_d;
  logic                             ac_q, ac_d;
  logic                             cio_q, cio_d;

  logic       push_en;
  logic       in_obj, in_arr, top_bit, not_full;
  logic [1:0] n;
  jter_pkg::evt_t ev_a, ev_b, opn;
  jter_pkg::tok_e kind;

  function automatic jter_pkg::evt_t mk_ev(jter_pkg::ev_e code, logic [63:0] bits,
                                           logic [15:0] vref, logic [15:0] vlen,
                                           logic keyed, logic [15:0] kref,
                                           logic [15:0] klen);
    jter_pkg::evt_t e;
    e.code    = code;
    e.bits    = bits;
    e.vref    = vref & jter_pkg::HMASK;
    e.vlen    = vlen;
    e.has_key = keyed && (klen != 16'd0);
    e.kref    = keyed ? (kref & jter_pkg::HMASK) : 16'd0;
    e.klen    = keyed ? klen : 16'd0;
    e.last    = 1'b0;
    return e;
  endfunction

  assign kind     = jter_pkg::tok_e'(tok_i.kind);
  assign lvl_m1   = lvl_q - jter_pkg::LVL_W'(1);
  assign top_bit  = stack_q[lvl_m1[jter_pkg::IDX_W-1:0]];
  assign in_obj   = (lvl_q != '0) && top_bit;
  assign in_arr   = (lvl_q != '0) && !top_bit;
  assign not_full = (lvl_q < jter_pkg::LVL_W'(jter_pkg::STACK_DEPTH));

  always_comb begin
    lvl_d     = lvl_q;
    key_ref_d = key_ref_q;
    key_len_d = key_len_q;
    ac_d      = ac_q;
    cio_d     = 1'b0;
    push_en   = 1'b0;
    n         = 2'd0;
    ev_a      = '0;
    ev_b      = '0;
    opn       = '0;
    unique case (kind)
      jter_pkg::TK_END: begin
        ev_a = mk_ev(jter_pkg::EV_END, '0, '0, '0, 1'b0, '0, '0);
        n    = 2'd1;
      end
      jter_pkg::TK_ERROR: begin
        ev_a = mk_ev(jter_pkg::EV_ERROR, '0, '0, '0, 1'b0, '0, '0);
        n    = 2'd1;
      end
      jter_pkg::TK_OBJ_OPEN, jter_pkg::TK_ARR_OPEN: begin
        if (not_full) begin
          opn     = mk_ev(jter_pkg::ev_e'(tok_i.kind), '0, '0, '0, 1'b0, '0, '0);
          push_en = 1'b1;
          lvl_d   = lvl_q + jter_pkg::LVL_W'(1);
        end else begin
          opn = mk_ev(jter_pkg::EV_ERROR, '0, '0, '0, 1'b0, '0, '0);
        end
        if (cio_q) begin
          // name event carries the pending key ahead of the open
          ev_a = mk_ev(jter_pkg::EV_NAME, '0, '0, '0, 1'b1, key_ref_q, key_len_q);
          ev_b = opn;
          n    = 2'd2;
        end else begin
          ev_a = opn;
          n    = 2'd1;
        end
        key_ref_d = '0;
        key_len_d = '0;
        ac_d      = 1'b0;
      end
      jter_pkg::TK_OBJ_CLOSE, jter_pkg::TK_ARR_CLOSE: begin
        ev_a = mk_ev(jter_pkg::ev_e'(tok_i.kind), '0, '0, '0, 1'b0, '0, '0);
        n    = 2'd1;
        if (lvl_q != '0) begin
          lvl_d = lvl_m1;
        end
        key_ref_d = '0;
        key_len_d = '0;
        ac_d      = 1'b0;
      end
      jter_pkg::TK_COLON: begin
        if (in_arr) begin
          ev_a = mk_ev(jter_pkg::EV_ERROR, '0, '0, '0, 1'b0, '0, '0);
          n    = 2'd1;
        end
        cio_d = in_obj;
        ac_d  = 1'b1;
      end
      jter_pkg::TK_COMMA: begin
        key_ref_d = '0;
        key_len_d = '0;
        ac_d      = 1'b0;
      end
      jter_pkg::TK_STRING: begin
        if (!in_obj || ac_q) begin
          ev_a = mk_ev(jter_pkg::EV_STRING, '0, tok_i.tref, tok_i.tlen, 1'b1,
                       key_ref_q, key_len_q);
          n    = 2'd1;
          if (key_len_q != 16'd0) begin
            key_ref_d = '0;
            key_len_d = '0;
          end
        end else begin
          // string before the colon becomes the key
          key_ref_d = tok_i.tref & jter_pkg::HMASK;
          key_len_d = tok_i.tlen;
        end
        ac_d = 1'b0;
      end
      jter_pkg::TK_UNSIGNED, jter_pkg::TK_INTEGER, jter_pkg::TK_FLOAT,
      jter_pkg::TK_BOOL, jter_pkg::TK_NULL: begin
        ev_a = mk_ev(jter_pkg::ev_e'(tok_i.kind - 4'd1), tok_i.payload, '0, '0, 1'b1,
                     key_ref_q, key_len_q);
        if (kind == jter_pkg::TK_BOOL) begin
          ev_a.bits = {63'd0, tok_i.payload != 64'd0};
        end else if (kind == jter_pkg::TK_NULL) begin
          ev_a.bits = '0;
        end
        n = 2'd1;
        if (key_len_q != 16'd0) begin
          key_ref_d = '0;
          key_len_d = '0;
        end
        ac_d = 1'b0;
      end
      default: begin
      end
    endcase
    if (n == 2'd2) begin
      ev_b.last = 1'b1;
    end else begin
      ev_a.last = 1'b1;
    end
  end

  assign wr_o.cnt = fire_i ? n : 2'd0;
  assign wr_o.ev0 = ev_a;
  assign wr_o.ev1 = ev_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q     <= '0;
      key_ref_q <= '0;
      key_len_q <= '0;
      ac_q      <= 1'b0;
      cio_q     <= 1'b0;
    end else if (fire_i) begin
      lvl_q     <= lvl_d;
      key_ref_q <= key_ref_d;
      key_len_q <= key_len_d;
      ac_q      <= ac_d;
      cio_q     <= cio_d;
    end
  end

  // layer stack: 1 = object, 0 = array; only entries below the level are read
  always_ff @(posedge clk_i) begin
    if (fire_i && push_en) begin
      stack_q[lvl_q[jter_pkg::IDX_W-1:0]] <= (kind == jter_pkg::TK_OBJ_OPEN);
    end
  end

endmodule

`default_nettype wire

// File: src/jter_evq.sv
// ----------------------------------------------------------------------------
// JSON token reader event queue
// Small result queue; takes up to two events per cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module jter_evq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire jter_pkg::evq_wr_t wr_i,
  input  wire logic              pop_i,
  output logic                   room2_o,
  output logic                   valid_o,
  output jter_pkg::evt_t         head_o
);

  jter_pkg::evt_t                 mem_q [jter_pkg::EVQ_DEPTH];
  logic [jter_pkg::EVQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_p1;
  logic [jter_pkg::EVQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                           pop;

  assign valid_o   = (cnt_q != '0);
  assign pop       = pop_i && valid_o;
  assign room2_o   = (cnt_q <= jter_pkg::EVQ_CNT_W'(jter_pkg::EVQ_DEPTH - 2));
  assign head_o    = mem_q[rd_ptr_q];
  assign wr_ptr_p1 = wr_ptr_q + jter_pkg::EVQ_PTR_W'(1);
  assign cnt_d     = cnt_q + jter_pkg::EVQ_CNT_W'(wr_i.cnt)
                     - jter_pkg::EVQ_CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + jter_pkg::EVQ_PTR_W'(wr_i.cnt);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + jter_pkg::EVQ_PTR_W'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= wr_i.ev0;
    end
    if (wr_i.cnt == 2'd2) begin
      mem_q[wr_ptr_p1] <= wr_i.ev1;
    end
  end

endmodule

`default_nettype wire

// File: src/jter_checker.sv
// ----------------------------------------------------------------------------
// JSON token reader port checker
// Concurrent checks on the event port, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module jter_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [3:0]  event_res_o,
  input wire logic [63:0] value_bits_o,
  input wire logic        has_key_o,
  input wire logic [15:0] key_ref_o,
  input wire logic [15:0] key_len_o,
  input wire logic        last_o
);

  // stalled event holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(event_res_o) && $stable(value_bits_o) && $stable(last_o))
    else $error("event changed while stalled");

  // structural events never carry a key
  a_nokey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o == jter_pkg::EV_END || event_res_o == jter_pkg::EV_ERROR
      || event_res_o == jter_pkg::EV_OBJ_OPEN || event_res_o == jter_pkg::EV_OBJ_CLOSE
      || event_res_o == jter_pkg::EV_ARR_OPEN || event_res_o == jter_pkg::EV_ARR_CLOSE)
    |-> !has_key_o && key_ref_o == 16'd0 && key_len_o == 16'd0)
    else $error("key on structural event");

  a_haskey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_key_o |-> key_len_o != 16'd0)
    else $error("has_key with empty key");

  // name event is never marked last, since its open or error always follows it
  a_name: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == jter_pkg::EV_NAME |-> !last_o)
    else $error("name event marked last");

endmodule

bind json_token_to_event_reader jter_checker u_jter_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .event_res_o  (event_res_o),
  .value_bits_o (value_bits_o),
  .has_key_o    (has_key_o),
  .key_ref_o    (key_ref_o),
  .key_len_o    (key_len_o),
  .last_o       (last_o)
);

`default_nettype wire
